FILE: src/sha_pkg.sv
`default_nettype none
package sha_pkg;

    typedef enum logic [1:0] {
        ENG_IDLE  = 2'd0,
        ENG_ROUND = 2'd1,
        ENG_ADD   = 2'd2,
        ENG_EMIT  = 2'd3
    } eng_state_t;

    // One entry of the front-to-back queue: a full 512-bit block and whether
    // it ends a message (digest wanted after it).
    typedef struct packed {
        logic [511:0] block;
        logic         last;
    } blk_entry_t;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic       OP_ABSORB = 1'b0;
    localparam logic       OP_FINISH = 1'b1;

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

FILE: src/sha_front.sv
`default_nettype none
// Collects bytes into a block register, pads on finish, and pushes whole
// blocks into the queue. Padding needs one or two pushes.
module sha_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_operation,
    input  wire logic [7:0]          s_data_byte,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output sha_pkg::blk_entry_t      push_entry
);
    logic [511:0] blk_reg, blk_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  bits_reg, bits_next;
    logic         tail_reg, tail_next;   // second padding block still to push
    logic         pv_reg, pv_next;
    sha_pkg::blk_entry_t ent_reg, ent_next;

    logic [511:0] padded;
    logic [8:0]   shamt;

    assign s_ready    = !pv_reg && !tail_reg;
    assign push_valid = pv_reg;
    assign push_entry = ent_reg;

    always_comb begin
        shamt  = 9'(10'd504 - {1'b0, fill_reg, 3'b000});
        padded = blk_reg | (512'(sha_pkg::PAD_BYTE) << shamt);
        // Bytes past the pad marker are cleared.
        padded = padded & ({512{1'b1}} << shamt);
    end

    always_comb begin
        blk_next  = blk_reg;
        fill_next = fill_reg;
        bits_next = bits_reg;
        tail_next = tail_reg;
        pv_next   = pv_reg;
        ent_next  = ent_reg;
        if (pv_reg && push_ready) begin
            pv_next = 1'b0;
        end
        if (tail_reg && (!pv_reg || push_ready)) begin
            tail_next           = 1'b0;
            pv_next             = 1'b1;
            ent_next.block      = {448'd0, bits_reg};
            ent_next.last       = 1'b1;
            bits_next           = 64'd0;
        end else if (s_valid && s_ready) begin
            if (s_operation == sha_pkg::OP_ABSORB) begin
                blk_next  = blk_reg | (512'(s_data_byte) << (9'(10'd504 -
                            {1'b0, fill_reg, 3'b000})));
                fill_next = fill_reg + 6'd1;
                bits_next = bits_reg + 64'd8;
                if (fill_reg == 6'd63) begin
                    pv_next        = 1'b1;
                    ent_next.block = blk_next;
                    ent_next.last  = 1'b0;
                    blk_next       = '0;
                end
            end else begin
                pv_next   = 1'b1;
                blk_next  = '0;
                fill_next = 6'd0;
                if (fill_reg >= 6'd56) begin
                    ent_next.block = padded;
                    ent_next.last  = 1'b0;
                    tail_next      = 1'b1;
                end else begin
                    ent_next.block = {padded[511:64], bits_reg};
                    ent_next.last  = 1'b1;
                    bits_next      = 64'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_reg  <= '0;
            fill_reg <= '0;
            bits_reg <= '0;
            tail_reg <= 1'b0;
            pv_reg   <= 1'b0;
        end else begin
            blk_reg  <= blk_next;
            fill_reg <= fill_next;
            bits_reg <= bits_next;
            tail_reg <= tail_next;
            pv_reg   <= pv_next;
        end
        ent_reg <= ent_next;
    end
endmodule
`default_nettype wire

FILE: src/sha_queue.sv
`default_nettype none
// Two-entry block queue between the collector and the compression engine.
module sha_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sha_pkg::blk_entry_t in_entry,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output sha_pkg::blk_entry_t      out_entry
);
    sha_pkg::blk_entry_t slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_entry = slot_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
        if (wr) slot_reg[wp_reg] <= in_entry;
    end
endmodule
`default_nettype wire

FILE: src/sha_engine.sv
`default_nettype none
// One SHA-256 round per cycle over a 16-word sliding schedule, then the
// chaining add, then (for a closing block) eight digest transfers.
module sha_engine (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                blk_valid,
    output logic                     blk_ready,
    input  wire sha_pkg::blk_entry_t blk_entry,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [31:0]              m_digest_word,
    output logic [2:0]               m_word_index,
    output logic                     m_last_word
);
    sha_pkg::eng_state_t state_reg, state_next;
    logic [255:0] h_reg, h_next;
    logic [255:0] v_reg, v_next;
    logic [511:0] w_reg, w_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic [2:0]   idx_reg, idx_next;
    logic         last_reg, last_next;

    logic [31:0] a, b, c, d, e, f, g, hh, w0, w1, w9, w14;
    logic [31:0] s0, s1, wnew, big0, big1, ch, maj, t1, t2;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb begin
        {a, b, c, d, e, f, g, hh} = v_reg;
        w0   = w_reg[511:480];
        w1   = w_reg[479:448];
        w9   = w_reg[223:192];
        w14  = w_reg[63:32];
        s0   = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
        s1   = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
        wnew = w0 + s0 + w9 + s1;
        big1 = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
        ch   = (e & f) ^ (~e & g);
        big0 = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
        maj  = (a & b) ^ (a & c) ^ (b & c);
        t1   = hh + big1 + ch + sha_pkg::round_const(rnd_reg) + w0;
        t2   = big0 + maj;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sha_pkg::ENG_IDLE:  if (blk_valid) state_next = sha_pkg::ENG_ROUND;
            sha_pkg::ENG_ROUND: if (rnd_reg == 6'd63) state_next = sha_pkg::ENG_ADD;
            sha_pkg::ENG_ADD:   state_next = last_reg ? sha_pkg::ENG_EMIT : sha_pkg::ENG_IDLE;
            sha_pkg::ENG_EMIT:  if (m_ready && idx_reg == 3'd7) state_next = sha_pkg::ENG_IDLE;
            default:            state_next = sha_pkg::ENG_IDLE;
        endcase
    end

    always_comb begin
        blk_ready = 1'b0;
        m_valid   = 1'b0;
        h_next    = h_reg;
        v_next    = v_reg;
        w_next    = w_reg;
        rnd_next  = rnd_reg;
        idx_next  = idx_reg;
        last_next = last_reg;
        case (state_reg)
            sha_pkg::ENG_IDLE: begin
                blk_ready = 1'b1;
                if (blk_valid) begin
                    w_next    = blk_entry.block;
                    last_next = blk_entry.last;
                    v_next    = h_reg;
                    rnd_next  = 6'd0;
                end
            end
            sha_pkg::ENG_ROUND: begin
                v_next   = {t1 + t2, a, b, c, d + t1, e, f, g};
                w_next   = {w_reg[479:0], wnew};
                rnd_next = rnd_reg + 6'd1;
            end
            sha_pkg::ENG_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    h_next[i*32 +: 32] = h_reg[i*32 +: 32] + v_reg[i*32 +: 32];
                end
                idx_next = 3'd0;
            end
            sha_pkg::ENG_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    idx_next = idx_reg + 3'd1;
                    h_next   = {h_reg[223:0], 32'd0};
                    if (idx_reg == 3'd7) h_next = sha_pkg::INIT_HASH;
                end
            end
            default: ;
        endcase
    end

    assign m_digest_word = h_reg[255:224];
    assign m_word_index  = idx_reg;
    assign m_last_word   = (idx_reg == 3'd7);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha_pkg::ENG_IDLE;
            h_reg     <= sha_pkg::INIT_HASH;
            idx_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            h_reg     <= h_next;
            idx_reg   <= idx_next;
        end
        v_reg    <= v_next;
        w_reg    <= w_next;
        rnd_reg  <= rnd_next;
        last_reg <= last_next;
    end
endmodule
`default_nettype wire

FILE: src/sha256_stream_hasher.sv
`default_nettype none
// A finish yields the first digest word once the closing block has been compressed
// (two blocks when padding spills into a second block).
// Bytes are taken one per cycle while s_ready is high; s_ready drops while a block
// waits to be pushed, and the engine, at one round per cycle, limits the sustained rate.
// Reset (synchronous, active low) restores the initial hash and empties the queue.
module sha256_stream_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_last_word
);
    // The front collects bytes and pads, and hands whole blocks across a
    // two-entry queue so bytes keep streaming while the engine compresses.
    logic                q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    sha_pkg::blk_entry_t q_in_entry, q_out_entry;

    sha_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_data_byte(s_data_byte),
        .push_valid(q_in_valid), .push_ready(q_in_ready), .push_entry(q_in_entry)
    );

    sha_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_in_valid), .in_ready(q_in_ready), .in_entry(q_in_entry),
        .out_valid(q_out_valid), .out_ready(q_out_ready), .out_entry(q_out_entry)
    );

    // The engine emits each digest word as one transfer on the m_ channel.
    sha_engine u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .blk_valid(q_out_valid), .blk_ready(q_out_ready), .blk_entry(q_out_entry),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_digest_word(m_digest_word), .m_word_index(m_word_index),
        .m_last_word(m_last_word)
    );
endmodule
`default_nettype wire
